[hw/rtl/pwo_pkg.sv]
// ----------------------------------------------------------------------------
// pwo_pkg
// Shared types and constants for the pitch window octave jump detector.
// ----------------------------------------------------------------------------
package pwo_pkg;

  // Window and field sizes
  localparam int WINDOW_DEPTH = 5;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  // count must also hold WINDOW_DEPTH + 1 for the overflow check
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 2);
  localparam int PITCH_W      = 16;
  localparam int MEAN_W       = 15;
  localparam int SHIFT_W      = 5;
  localparam int COUNT_OUT_W  = 3;

  // Q7.8 constants
  localparam int OCTAVE_Q8    = 3072;
  localparam int NEAR_Q8      = 2560;
  localparam int MEAN_MAX     = 32767;

  // Datapath widths
  localparam int DIV_W        = PITCH_W + 1;   // signed difference of two pitches
  localparam int MAG_W        = PITCH_W;       // magnitude of that difference
  localparam int STEP_W       = $clog2(MAG_W);
  localparam int OCT_W        = PITCH_W + 2;   // octave search pitch and distance

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic                      clear;
  } pwo_in_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] octave_shift;
    logic [MEAN_W-1:0]         voiced_mean;
    logic [COUNT_OUT_W-1:0]    voiced_count;
  } pwo_out_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_CALC
  } pwo_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } pwo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic calc_done;
    logic out_free;
  } pwo_sts_t;

endpackage

[hw/rtl/pitch_window_octave_jump_detector.sv]
// ----------------------------------------------------------------------------
// pitch_window_octave_jump_detector
// Octave jump detector over a short window of Q7.8 pitch frames.
// ----------------------------------------------------------------------------
// One frame is taken at a time. The controller takes the frame, the
// bit-serial divider forms the mean correction (one quotient bit a cycle),
// and the update is then committed into the result register once that
// register is free. The octave search (at most 10 steps) runs alongside the
// divide. The result sits in its own register, so the next frame is taken
// while it waits. Clear frames take the same time.
module pitch_window_octave_jump_detector (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_ready,
  input  pwo_pkg::pwo_in_t  frame,
  output logic              result_valid,
  input  logic              result_ready,
  output pwo_pkg::pwo_out_t result
);
  import pwo_pkg::*;

  pwo_cmd_t cmd;
  pwo_sts_t sts;

  pwo_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pwo_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[hw/rtl/pwo_div.sv]
// ----------------------------------------------------------------------------
// pwo_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pwo_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pwo_pkg::DIV_W-1:0]  num,
  input  logic [pwo_pkg::CNT_W-1:0]         den,
  output logic signed [pwo_pkg::DIV_W-1:0]  quo,
  output logic                              done
);
  import pwo_pkg::*;

  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem;
  logic [MAG_W-1:0]  quo_sh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              neg;

  logic [DIV_W-1:0]  num_abs;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  // magnitude of the dividend
  assign num_abs = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);

  // restoring step
  assign rem_sh  = {rem, quo_sh[MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(MAG_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q  <= den;
      neg    <= num[DIV_W-1];
      rem    <= '0;
      quo_sh <= num_abs[MAG_W-1:0];
    end else if (busy) begin
      rem    <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_sh <= {quo_sh[MAG_W-2:0], ge};
    end
  end

  assign done = !busy;
  assign quo  = neg ? -$signed({1'b0, quo_sh}) : $signed({1'b0, quo_sh});

endmodule

[hw/rtl/pwo_dp.sv]
// ----------------------------------------------------------------------------
// pwo_dp
// Datapath: pitch ring, voiced count, running mean, octave search, divider
// and the result register.
// ----------------------------------------------------------------------------
module pwo_dp (
  input  logic              clk,
  input  logic              rst,
  input  pwo_pkg::pwo_cmd_t cmd,
  output pwo_pkg::pwo_sts_t sts,
  input  pwo_pkg::pwo_in_t  frame,
  output logic              result_valid,
  input  logic              result_ready,
  output pwo_pkg::pwo_out_t result
);
  import pwo_pkg::*;

  // History state
  logic signed [PITCH_W-1:0] ring [WINDOW_DEPTH];
  logic [SLOT_W-1:0]         slot;
  logic [CNT_W-1:0]          cnt;
  logic [MEAN_W-1:0]         mean;

  // Captured item
  logic signed [PITCH_W-1:0] p_q;
  logic signed [PITCH_W-1:0] prev_q;
  logic                      clr_q;

  // Octave search
  logic signed [OCT_W-1:0]   oct_p;
  logic                      oct_up;
  logic signed [SHIFT_W-1:0] oct_shift;
  logic                      oct_done;

  // Divider
  logic signed [DIV_W-1:0]   div_num;
  logic [CNT_W-1:0]          div_den;
  logic signed [DIV_W-1:0]   div_quo;
  logic                      div_done;

  // ---- load side: decode the incoming frame against current state --------
  logic signed [PITCH_W-1:0] p_in;
  logic signed [PITCH_W-1:0] prev_in;
  logic                      nv_in;
  logic                      wv_in;
  logic signed [DIV_W-1:0]   p_in_x;
  logic signed [DIV_W-1:0]   prev_in_x;
  logic signed [DIV_W-1:0]   mean_x;
  logic signed [OCT_W-1:0]   p_in_o;
  logic signed [OCT_W-1:0]   mean_o;

  assign p_in      = frame.pitch;
  assign prev_in   = ring[slot];
  assign nv_in     = p_in > $signed(PITCH_W'(0));
  assign wv_in     = prev_in > $signed(PITCH_W'(0));
  assign p_in_x    = {p_in[PITCH_W-1], p_in};
  assign prev_in_x = {prev_in[PITCH_W-1], prev_in};
  assign mean_x    = $signed({{(DIV_W-MEAN_W){1'b0}}, mean});
  assign p_in_o    = {{(OCT_W-PITCH_W){p_in[PITCH_W-1]}}, p_in};
  assign mean_o    = $signed({{(OCT_W-MEAN_W){1'b0}}, mean});

  // slot turning voiced divides by the raised count, otherwise by the count (one when it is zero)
  always_comb begin
    if (nv_in && !wv_in) begin
      div_num = p_in_x - mean_x;
      div_den = cnt + CNT_W'(1);
    end else begin
      div_num = p_in_x - prev_in_x;
      div_den = (cnt == '0) ? CNT_W'(1) : cnt;
    end
  end

  pwo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // ---- octave search: one octave step per cycle toward the mean ----------
  logic signed [OCT_W-1:0] oct_diff;
  logic [OCT_W-1:0]        oct_dist;

  assign oct_diff = oct_p - mean_o;
  assign oct_dist = oct_diff[OCT_W-1] ? OCT_W'(-oct_diff) : OCT_W'(oct_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      oct_done <= 1'b1;
    end else if (cmd.load) begin
      oct_done <= frame.clear || (cnt == '0) || !nv_in;
    end else if (!oct_done && (oct_dist <= OCT_W'(NEAR_Q8))) begin
      oct_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oct_p     <= p_in_o;
      oct_up    <= p_in_o > mean_o;
      oct_shift <= '0;
    end else if (!oct_done && (oct_dist > OCT_W'(NEAR_Q8))) begin
      if (oct_up) begin
        oct_p     <= oct_p - OCT_W'(OCTAVE_Q8);
        oct_shift <= oct_shift + SHIFT_W'(1);
      end else begin
        oct_p     <= oct_p + OCT_W'(OCTAVE_Q8);
        oct_shift <= oct_shift - SHIFT_W'(1);
      end
    end
  end

  // ---- capture of the item ----------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_q    <= p_in;
      prev_q <= prev_in;
      clr_q  <= frame.clear;
    end
  end

  // ---- commit side: new count, mean and wipe decision --------------------
  logic                    nv_q;
  logic                    wv_q;
  logic                    go_up;
  logic                    go_down;
  logic                    stay_v;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        cnt_new;
  logic signed [OCT_W-1:0] mean_sum;
  logic [MEAN_W-1:0]       mean_sat;
  logic [MEAN_W-1:0]       mean_new;
  logic                    wipe;
  logic [SLOT_W-1:0]       slot_inc;

  assign nv_q     = p_q > $signed(PITCH_W'(0));
  assign wv_q     = prev_q > $signed(PITCH_W'(0));
  assign go_up    = nv_q && !wv_q;
  assign go_down  = !nv_q && wv_q;
  assign stay_v   = nv_q && wv_q;
  assign cnt_inc  = cnt + CNT_W'(1);
  assign mean_sum = mean_o + {{(OCT_W-DIV_W){div_quo[DIV_W-1]}}, div_quo};
  assign slot_inc = (slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);

  // saturate the mean to its unsigned Q7.8 range
  always_comb begin
    if (mean_sum[OCT_W-1]) begin
      mean_sat = '0;
    end else if (mean_sum > $signed(OCT_W'(MEAN_MAX))) begin
      mean_sat = MEAN_W'(MEAN_MAX);
    end else begin
      mean_sat = mean_sum[MEAN_W-1:0];
    end
  end

  always_comb begin
    if (go_up) begin
      cnt_new = cnt_inc;
    end else if (go_down) begin
      cnt_new = cnt - CNT_W'(1);
    end else begin
      cnt_new = cnt;
    end
    mean_new = (go_up || stay_v) ? mean_sat : mean;
    wipe     = clr_q
            || (go_up && (cnt_inc > CNT_W'(WINDOW_DEPTH)))
            || (go_down && (cnt <= CNT_W'(1)));
  end

  // history update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring[i] <= '0;
      end
      slot <= '0;
      cnt  <= '0;
      mean <= '0;
    end else if (cmd.commit) begin
      if (wipe) begin
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
          ring[i] <= '0;
        end
        cnt  <= '0;
        mean <= '0;
        // after a wipe a real frame still lands at slot 0
        if (clr_q) begin
          ring[0] <= '0;
          slot    <= '0;
        end else begin
          ring[0] <= p_q;
          slot    <= SLOT_W'(1);
        end
      end else begin
        ring[slot] <= p_q;
        slot       <= slot_inc;
        cnt        <= cnt_new;
        mean       <= mean_new;
      end
    end
  end

  // ---- result register ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.octave_shift <= clr_q ? '0 : oct_shift;
      result.voiced_mean  <= wipe ? '0 : mean_new;
      result.voiced_count <= wipe ? '0 : COUNT_OUT_W'(cnt_new);
    end
  end

  assign sts.calc_done = oct_done && div_done;
  assign sts.out_free  = !result_valid || result_ready;

endmodule

[hw/rtl/pwo_ctrl.sv]
// ----------------------------------------------------------------------------
// pwo_ctrl
// Controller: takes a frame, waits for the octave search and the divide,
// then commits the update once the result register is free.
// ----------------------------------------------------------------------------
module pwo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_ready,
  input  pwo_pkg::pwo_sts_t sts,
  output pwo_pkg::pwo_cmd_t cmd
);
  import pwo_pkg::*;

  pwo_state_t state;
  pwo_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (sts.calc_done && sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    frame_ready = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        frame_ready = 1'b1;
        cmd.load    = frame_valid;
      end
      S_CALC: begin
        cmd.commit = sts.calc_done && sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/pwo_chk.sv]
// ----------------------------------------------------------------------------
// pwo_chk
// Port-level checks for the octave jump detector, bound to the top level.
// ----------------------------------------------------------------------------
module pwo_chk (
  input logic              clk,
  input logic              rst,
  input logic              frame_valid,
  input logic              frame_ready,
  input pwo_pkg::pwo_in_t  frame,
  input logic              result_valid,
  input logic              result_ready,
  input pwo_pkg::pwo_out_t result
);
  import pwo_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item in work at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("frame taken while another is in work");

  // a reported octave jump means some voiced frame is counted
  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.octave_shift != '0
      |-> (WINDOW_DEPTH > 7) || result.voiced_count != '0)
    else $error("octave shift with no voiced frames");

  // an empty window always has a zero mean
  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.voiced_count == '0
      |-> (WINDOW_DEPTH > 7) || result.voiced_mean == '0)
    else $error("non-zero mean with no voiced frames");

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> frame_ready && !result_valid)
    else $error("not idle after reset");

endmodule

bind pitch_window_octave_jump_detector pwo_chk u_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pitch window octave jump detector. Frames are
// sent over the valid/ready input channel in random bursts while the result
// channel stalls on its own pattern. Every accepted frame is run through a
// local model of the voiced window, and each result is checked field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import pwo_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     frame_valid  = 1'b0;
  logic     frame_ready;
  pwo_in_t  frame        = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  pwo_out_t result;

  // window history as seen by the predictor
  int hist_ring [WINDOW_DEPTH];
  int hist_slot;
  int hist_voiced;
  int hist_mean;

  pwo_out_t expected_results [$];
  int       errors = 0;

  // sender burst control
  bit tx_steady     = 1'b0;
  int tx_burst_left = 0;

  // receiver control
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_hold_req = 0;
  int       rx_hold_left = 0;
  int       rx_phase    = 0;

  pitch_window_octave_jump_detector DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window model
  // --------------------------------------------------------------------------
  function automatic void reset_history();
    foreach (hist_ring[i]) hist_ring[i] = 0;
    hist_slot   = 0;
    hist_voiced = 0;
    hist_mean   = 0;
  endfunction

  function automatic int clamp_mean(int m);
    if (m < 0) return 0;
    if (m > MEAN_MAX) return MEAN_MAX;
    return m;
  endfunction

  // whole octaves to take off p to land within reach of the mean
  function automatic int octave_distance(int p);
    int sign;
    int shift;
    int diff;
    int n;
    shift = 0;
    if (hist_voiced < 1 || p <= 0) return 0;
    sign = (p > hist_mean) ? 1 : -1;
    for (n = 0; n < 32; n++) begin
      diff = p - hist_mean;
      if (diff < 0) diff = -diff;
      if (diff <= NEAR_Q8) break;
      p     -= OCTAVE_Q8 * sign;
      shift += sign;
    end
    return shift;
  endfunction

  function automatic void update_history(int p);
    int prev;
    bit now_v;
    bit was_v;
    if (hist_slot >= WINDOW_DEPTH) reset_history();
    prev  = hist_ring[hist_slot];
    now_v = p > 0;
    was_v = prev > 0;
    if (now_v != was_v) begin
      if (now_v) begin
        hist_voiced++;
        if (hist_voiced > WINDOW_DEPTH) reset_history();
        else hist_mean = clamp_mean(hist_mean + (p - hist_mean) / hist_voiced);
      end else begin
        // leaving voiced slot: count drops, mean stays
        hist_voiced--;
        if (hist_voiced <= 0 || hist_voiced > WINDOW_DEPTH) reset_history();
      end
    end else if (now_v) begin
      hist_mean = clamp_mean(hist_mean + (p - prev) / ((hist_voiced < 1) ? 1 : hist_voiced));
    end
    hist_ring[hist_slot] = p;
    hist_slot = (hist_slot + 1) % WINDOW_DEPTH;
  endfunction

  function automatic pwo_out_t predict_frame(pwo_in_t f);
    pwo_out_t r;
    int       p;
    int       shift;
    p     = $signed(f.pitch);
    shift = 0;
    if (f.clear) begin
      reset_history();
    end else begin
      shift = octave_distance(p);
      update_history(p);
    end
    r.octave_shift = shift[SHIFT_W-1:0];
    r.voiced_mean  = hist_mean[MEAN_W-1:0];
    r.voiced_count = hist_voiced[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // append a predicted result behind the ones still pending
  function automatic void queue_expected(pwo_out_t r);
    expected_results = {expected_results, r};
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check results first, then log the accepted frame
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pwo_out_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no frame pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.octave_shift !== want.octave_shift) begin
            $error("octave_shift: expected %0d, actual %0d",
                   $signed(want.octave_shift), $signed(result.octave_shift));
            errors++;
          end
          if (result.voiced_mean !== want.voiced_mean) begin
            $error("voiced_mean: expected %0d, actual %0d",
                   want.voiced_mean, result.voiced_mean);
            errors++;
          end
          if (result.voiced_count !== want.voiced_count) begin
            $error("voiced_count: expected %0d, actual %0d",
                   want.voiced_count, result.voiced_count);
            errors++;
          end
        end
      end
      if (frame_valid && frame_ready) queue_expected(predict_frame(frame));
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   result_ready <= 1'b1;
          RX_RANDOM: result_ready <= ($urandom_range(0, 99) < 60);
          default: begin
            rx_phase = (rx_phase + 1) % 11;
            result_ready <= (rx_phase < 3 || rx_phase == 7);
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_frame(logic [PITCH_W-1:0] value, logic clr);
    frame       <= '{pitch: value, clear: clr};
    frame_valid <= 1'b1;
    do @(posedge clk); while (!frame_ready);
    if (!tx_steady) begin
      if (tx_burst_left > 0) begin
        tx_burst_left--;
      end else begin
        tx_burst_left = $urandom_range(0, 10);
        frame_valid <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  endtask

  task automatic sender_idle(int cycles);
    frame_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    sender_idle(1);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Frame generators
  // --------------------------------------------------------------------------
  function automatic logic [PITCH_W-1:0] unvoiced_pitch();
    int v;
    if ($urandom_range(0, 9) < 3) v = 0;
    else v = -int'($urandom_range(1, 32768));
    return v[PITCH_W-1:0];
  endfunction

  // mostly near the centre, some octave jumps, some noise and extremes
  function automatic logic [PITCH_W-1:0] random_pitch(int centre);
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = centre + int'($urandom_range(0, 1536)) - 768;
    end else if (pick < 75) begin
      v = centre + OCTAVE_Q8 * (int'($urandom_range(0, 6)) - 3)
          + int'($urandom_range(0, 512)) - 256;
    end else if (pick < 85) begin
      return unvoiced_pitch();
    end else if (pick < 95) begin
      v = $urandom_range(0, 65535);
      return v[PITCH_W-1:0];
    end else begin
      v = $urandom_range(0, 1) ? 32767 : 1;
    end
    if (v < 1) v = 1;
    if (v > 32767) v = 32767;
    return v[PITCH_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // first frames out of reset and the pitch extremes
  task automatic test_field_extremes();
    send_frame(16'sd0, 1'b0);
    send_frame(16'sd1, 1'b0);
    send_frame(16'sd32767, 1'b0);
    send_frame(16'h8000, 1'b0);
    send_frame(16'hFFFF, 1'b0);
    send_frame(16'h5555, 1'b0);
    send_frame(16'hAAAA, 1'b0);
  endtask

  // clear flag ignores the pitch
  task automatic test_clear_flag();
    send_frame(16'sd32767, 1'b1);
    send_frame(16'sd5000, 1'b0);
    send_frame(16'h8000, 1'b1);
  endtask

  // voiced frame replaced after a silent window: count falls to zero
  task automatic test_count_to_zero();
    send_frame(16'sd3000, 1'b0);
    repeat (4) send_frame(16'sd0, 1'b0);
    send_frame(16'sd0, 1'b0);
    send_frame(16'sd4000, 1'b0);
  endtask

  // stale mean after a voiced slot leaves: drive it past both rails
  task automatic test_mean_saturation();
    send_frame(16'sd0, 1'b1);
    send_frame(16'sd32767, 1'b0);
    send_frame(16'sd100, 1'b0);
    repeat (4) send_frame(16'sd0, 1'b0);
    send_frame(16'sd32767, 1'b0);
    send_frame(16'sd0, 1'b1);
    send_frame(16'sd100, 1'b0);
    send_frame(16'sd32767, 1'b0);
    repeat (4) send_frame(16'sd0, 1'b0);
    send_frame(16'sd1, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_output_stall();
    int i;
    wait_results_drained();
    rx_mode     = RX_OPEN;
    rx_hold_req = 400;
    tx_steady   = 1'b1;
    for (i = 0; i < 12; i++) send_frame(random_pitch(15000), 1'b0);
    tx_steady = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_frames();
    int phase;
    int n;
    int centre;
    int pick;
    for (phase = 0; phase < 11; phase++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       rx_mode = RX_OPEN;
        1:       rx_mode = RX_RANDOM;
        default: rx_mode = RX_PATTERN;
      endcase
      centre = $urandom_range(0, 1) ? $urandom_range(10240, 23040) : $urandom_range(1, 32767);
      n = 0;
      while (n < 150) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_frame(16'($urandom_range(0, 65535)), 1'b1);
          n++;
        end else if (pick < 5) begin
          // a burst of silence; its longer runs empty the window
          repeat ($urandom_range(3, 6)) begin
            send_frame(unvoiced_pitch(), 1'b0);
            n++;
          end
        end else if (pick < 8) begin
          centre = $urandom_range(1, 32767);
        end else begin
          send_frame(random_pitch(centre), 1'b0);
          n++;
        end
      end
      if (phase == 5) wait_results_drained();
    end
    tx_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_history();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_clear_flag();
    test_count_to_zero();
    test_mean_saturation();
    test_output_stall();
    rx_mode = RX_RANDOM;
    test_random_frames();
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("pitch_window_octave_jump_detector regression: pass");
    end else begin
      $display("pitch_window_octave_jump_detector regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("pitch_window_octave_jump_detector regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pwo_pkg.sv
hw/rtl/pwo_div.sv
hw/rtl/pwo_dp.sv
hw/rtl/pwo_ctrl.sv
hw/rtl/pitch_window_octave_jump_detector.sv
hw/rtl/pwo_chk.sv
test/tb_top.sv
